### rtl/mts_pkg.sv
// mts_pkg: shared types and codes of the midpoint triangle subdivider
// no dependencies; imported by midpoint_triangle_subdivider_unit and its testbench
package mts_pkg;

    // input commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SPLIT  = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_DEFER  = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    // configuration register indexes
    localparam logic REG_SPLIT_MODE  = 1'b0;
    localparam logic REG_Z_THRESHOLD = 1'b1;

    localparam int IDX_W   = 12;
    localparam int KEY_W   = 2 * IDX_W;
    localparam int EPOCH_W = 4;
    localparam int CMP_W   = 50;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = {{(EPOCH_W-1){1'b0}}, 1'b1};

    // edge cache entry, stale when tag differs from the current epoch
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   mid;
    } edge_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPEND,
        ST_Z0,
        ST_Z1,
        ST_Z2,
        ST_Z3,
        ST_PROBE,
        ST_PCHK,
        ST_VP,
        ST_VQ,
        ST_VS,
        ST_MID,
        ST_NEXT,
        ST_TRI,
        ST_DEFER
    } state_t;

endpackage

### rtl/midpoint_triangle_subdivider_unit.sv
// midpoint_triangle_subdivider_unit: 1-to-4 midpoint subdivision with an edge cache
// depends on mts_pkg; vertex stores and edge cache are on-chip synchronous memories
//
//  channel | signals                         | direction | moves
//  --------+---------------------------------+-----------+---------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser| in        | one command request
//  m_      | m_tvalid m_tready m_tdata        | out       | one result, tlast on final
//          | m_tuser m_tlast                  |           |
//  cfg_    | cfg_valid cfg_ready cfg_index    | in        | register write request
//          | cfg_data                         |           |
//
// in split_mode 1 a split-pass request first runs the z check and may be deferred; it then
// probes each edge, creating each midpoint not yet cached, walks extra probe steps on collisions
// and gives one result per triangle; a fill-pass request probes each edge, then gives tris
// after reset the cache is swept once, and again on every fifteenth clear; no request is
// taken during the sweep.
// results wait in one output register; a stalled m_tready holds the sequencer.
module midpoint_triangle_subdivider_unit #(
    parameter int VERTEX_SLOTS = 4096,
    parameter int EDGE_SLOTS   = 8192,
    parameter int COORD_WIDTH  = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, vert_a, vert_b, vert_c, 4 zero bits
    input  logic [135:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_index, mid_x, mid_y, mid_z, tri_first, tri_second, tri_third
    output logic [143:0] m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import mts_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int VAW  = $clog2(VERTEX_SLOTS);
    localparam int VCW  = $clog2(VERTEX_SLOTS + 1);
    localparam int ECW  = $clog2(EDGE_SLOTS + 1);
    localparam int HAW  = $clog2(EDGE_SLOTS) + 1;
    localparam int HTD  = 1 << HAW;

    // fold the pair key into a cache address
    function automatic logic [HAW-1:0] edge_hash(input logic [KEY_W-1:0] key);
        logic [HAW-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % HAW] = h[i % HAW] ^ key[i];
        end
        return h;
    endfunction

    // memories
    logic signed [CW-1:0] x_mem [VERTEX_SLOTS];
    logic signed [CW-1:0] y_mem [VERTEX_SLOTS];
    logic signed [CW-1:0] z_mem [VERTEX_SLOTS];
    edge_entry_t          ht_mem [HTD];

    state_t state_reg, state_next;

    // configuration
    logic               split_mode_reg;
    logic signed [31:0] z_thr_reg;

    // request registers
    logic [1:0]          cmd_reg;
    logic signed [31:0]  px_in_reg, py_in_reg, pz_in_reg;
    logic [IDX_W-1:0]    va_reg, vb_reg, vc_reg;

    // mesh state
    logic [VCW-1:0]     vcount_reg, vcount_next;
    logic [ECW-1:0]     ecount_reg, ecount_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [HAW-1:0]     clr_addr_reg, clr_addr_next;

    // per-request work registers
    logic [1:0]         edge_reg, edge_next;
    logic [HAW-1:0]     h_reg, h_next;
    logic [2:0]         hits_reg, hits_next;
    logic [IDX_W-1:0]   mab_reg, mac_reg, mcb_reg;
    logic [IDX_W-1:0]   mid_idx_next;
    logic               mid_we;
    logic               big_reg, big_next;
    logic [1:0]         tcnt_reg, tcnt_next;
    logic signed [CW-1:0] ax_reg, ay_reg, az_reg;
    logic signed [CW-1:0] mx_reg, my_reg, mz_reg;

    // memory ports
    logic [IDX_W-1:0]     v_raddr;
    logic                 v_ok_reg;
    logic signed [CW-1:0] x_rd_reg, y_rd_reg, z_rd_reg;
    logic signed [CW-1:0] x_rd, y_rd, z_rd;
    logic                 v_we;
    logic [VAW-1:0]       v_waddr;
    logic signed [CW-1:0] v_wx, v_wy, v_wz;
    logic [HAW-1:0]       ht_raddr;
    edge_entry_t          ht_rd_reg;
    logic                 ht_we;
    logic [HAW-1:0]       ht_waddr;
    edge_entry_t          ht_wdata;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [IDX_W-1:0]     out_idx_reg, out_t0_reg, out_t1_reg, out_t2_reg;
    logic signed [31:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                 out_last_reg;
    logic                 out_free, out_load;
    logic [1:0]           o_kind;
    logic [IDX_W-1:0]     o_idx, o_t0, o_t1, o_t2;
    logic signed [31:0]   o_x, o_y, o_z;
    logic                 o_last;

    // edge being worked on
    logic [IDX_W-1:0] ep, eq;
    logic [KEY_W-1:0] ekey;
    logic             s_fire;
    logic             vfull, efull;
    logic signed [CW:0] sx, sy, sz;

    // triangle selection
    logic [2:0]       pat;
    logic [2:0]       ntri;
    logic [IDX_W-1:0] tt0, tt1, tt2;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign vfull     = vcount_reg >= VCW'(VERTEX_SLOTS);
    assign efull     = ecount_reg >= ECW'(EDGE_SLOTS);

    always_comb begin
        case (edge_reg)
            2'd0:    begin ep = va_reg; eq = vb_reg; end
            2'd1:    begin ep = va_reg; eq = vc_reg; end
            default: begin ep = vc_reg; eq = vb_reg; end
        endcase
        ekey = (ep < eq) ? {ep, eq} : {eq, ep};
    end

    // vertex reads, out-of-range corners read as zero
    assign x_rd = v_ok_reg ? x_rd_reg : '0;
    assign y_rd = v_ok_reg ? y_rd_reg : '0;
    assign z_rd = v_ok_reg ? z_rd_reg : '0;

    always_ff @(posedge aclk) begin
        x_rd_reg <= x_mem[VAW'(v_raddr)];
        y_rd_reg <= y_mem[VAW'(v_raddr)];
        z_rd_reg <= z_mem[VAW'(v_raddr)];
        v_ok_reg <= 32'(v_raddr) < VERTEX_SLOTS;
        if (v_we) begin
            x_mem[v_waddr] <= v_wx;
            y_mem[v_waddr] <= v_wy;
            z_mem[v_waddr] <= v_wz;
        end
    end

    always_ff @(posedge aclk) begin
        ht_rd_reg <= ht_mem[ht_raddr];
        if (ht_we) begin
            ht_mem[ht_waddr] <= ht_wdata;
        end
    end

    // midpoint sums, arithmetic halving drops the low bit
    assign sx = (CW+1)'(ax_reg) + (CW+1)'(x_rd);
    assign sy = (CW+1)'(ay_reg) + (CW+1)'(y_rd);
    assign sz = (CW+1)'(az_reg) + (CW+1)'(z_rd);

    // triangle list for the current pattern (ab, ac, cb hit bits from the low bit)
    assign pat = (cmd_reg == CMD_SPLIT) ? 3'b111 : hits_reg;

    always_comb begin
        tt0 = va_reg; tt1 = vb_reg; tt2 = vc_reg; ntri = 3'd1;
        if (pat[0] && pat[1] && pat[2]) begin
            ntri = 3'd4;
            case (tcnt_reg)
                2'd0:    begin tt0 = va_reg;  tt1 = mab_reg; tt2 = mac_reg; end
                2'd1:    begin tt0 = vb_reg;  tt1 = mcb_reg; tt2 = mab_reg; end
                2'd2:    begin tt0 = vc_reg;  tt1 = mac_reg; tt2 = mcb_reg; end
                default: begin tt0 = mab_reg; tt1 = mcb_reg; tt2 = mac_reg; end
            endcase
        end else if (pat[0] && pat[1]) begin
            ntri = 3'd3;
            case (tcnt_reg)
                2'd0:    begin tt0 = mab_reg; tt1 = mac_reg; tt2 = va_reg;  end
                2'd1:    begin tt0 = vc_reg;  tt1 = mac_reg; tt2 = vb_reg;  end
                default: begin tt0 = vb_reg;  tt1 = mac_reg; tt2 = mab_reg; end
            endcase
        end else if (pat[0]) begin
            ntri = 3'd2;
            case (tcnt_reg)
                2'd0:    begin tt0 = va_reg; tt1 = mab_reg; tt2 = vc_reg;  end
                default: begin tt0 = vb_reg; tt1 = vc_reg;  tt2 = mab_reg; end
            endcase
        end else if (pat[1] && pat[2]) begin
            ntri = 3'd3;
            case (tcnt_reg)
                2'd0:    begin tt0 = va_reg;  tt1 = mcb_reg; tt2 = mac_reg; end
                2'd1:    begin tt0 = mac_reg; tt1 = mcb_reg; tt2 = vc_reg;  end
                default: begin tt0 = vb_reg;  tt1 = mcb_reg; tt2 = va_reg;  end
            endcase
        end else if (pat[1]) begin
            ntri = 3'd2;
            case (tcnt_reg)
                2'd0:    begin tt0 = va_reg; tt1 = vb_reg; tt2 = mac_reg; end
                default: begin tt0 = vb_reg; tt1 = vc_reg; tt2 = mac_reg; end
            endcase
        end else if (pat[2]) begin
            ntri = 3'd2;
            case (tcnt_reg)
                2'd0:    begin tt0 = va_reg; tt1 = mcb_reg; tt2 = vc_reg;  end
                default: begin tt0 = va_reg; tt1 = vb_reg;  tt2 = mcb_reg; end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        vcount_next   = vcount_reg;
        ecount_next   = ecount_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        edge_next     = edge_reg;
        h_next        = h_reg;
        hits_next     = hits_reg;
        big_next      = big_reg;
        tcnt_next     = tcnt_reg;
        mid_we        = 1'b0;
        mid_idx_next  = ht_rd_reg.mid;
        v_raddr       = ep;
        v_we          = 1'b0;
        v_waddr       = vcount_reg[VAW-1:0];
        v_wx          = mx_reg;
        v_wy          = my_reg;
        v_wz          = mz_reg;
        ht_raddr      = edge_hash(ekey);
        ht_we         = 1'b0;
        ht_waddr      = h_reg;
        ht_wdata      = '{tag: epoch_reg, key: ekey, mid: vcount_reg[IDX_W-1:0]};
        out_load      = 1'b0;
        o_kind        = KIND_VERTEX;
        o_idx         = '0;
        o_x           = '0;
        o_y           = '0;
        o_z           = '0;
        o_t0          = '0;
        o_t1          = '0;
        o_t2          = '0;
        o_last        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ht_we         = 1'b1;
                ht_waddr      = clr_addr_reg;
                ht_wdata      = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == HAW'(HTD - 1)) begin
                    epoch_next = EPOCH_ONE;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                edge_next = 2'd0;
                hits_next = 3'b000;
                big_next  = 1'b0;
                tcnt_next = 2'd0;
                if (s_fire) begin
                    case (s_tuser)
                        CMD_APPEND: state_next = ST_APPEND;
                        CMD_SPLIT:  state_next = split_mode_reg ? ST_Z0 : ST_PROBE;
                        CMD_FILL:   state_next = ST_PROBE;
                        default: begin
                            vcount_next = '0;
                            ecount_next = '0;
                            if (epoch_reg == EPOCH_MAX) begin
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end else begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_last     = 1'b1;
                    state_next = ST_IDLE;
                    if (vfull) begin
                        o_kind = KIND_FULL;
                    end else begin
                        v_we        = 1'b1;
                        v_wx        = CW'(px_in_reg);
                        v_wy        = CW'(py_in_reg);
                        v_wz        = CW'(pz_in_reg);
                        o_idx       = vcount_reg[IDX_W-1:0];
                        o_x         = 32'(v_wx);
                        o_y         = 32'(v_wy);
                        o_z         = 32'(v_wz);
                        vcount_next = vcount_reg + 1'b1;
                    end
                end
            end
            ST_Z0: begin
                v_raddr    = va_reg;
                state_next = ST_Z1;
            end
            ST_Z1: begin
                v_raddr    = vb_reg;
                big_next   = CMP_W'(z_rd) > CMP_W'(z_thr_reg);
                state_next = ST_Z2;
            end
            ST_Z2: begin
                v_raddr    = vc_reg;
                big_next   = big_reg || (CMP_W'(z_rd) > CMP_W'(z_thr_reg));
                state_next = ST_Z3;
            end
            ST_Z3: begin
                if (big_reg || (CMP_W'(z_rd) > CMP_W'(z_thr_reg))) begin
                    state_next = ST_PROBE;
                end else begin
                    state_next = ST_DEFER;
                end
            end
            ST_DEFER: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_kind     = KIND_DEFER;
                    o_t0       = va_reg;
                    o_t1       = vb_reg;
                    o_t2       = vc_reg;
                    o_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE: begin
                ht_raddr   = edge_hash(ekey);
                h_next     = edge_hash(ekey);
                state_next = ST_PCHK;
            end
            ST_PCHK: begin
                // keep the slot on the read port while waiting for the output
                ht_raddr = h_reg;
                if (ht_rd_reg.tag == epoch_reg && ht_rd_reg.key == ekey) begin
                    mid_we              = 1'b1;
                    hits_next[edge_reg] = 1'b1;
                    state_next          = ST_NEXT;
                end else if (ht_rd_reg.tag != epoch_reg) begin
                    // empty slot: the pair is not cached
                    if (cmd_reg == CMD_FILL) begin
                        state_next = ST_NEXT;
                    end else if (vfull || efull) begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            o_kind     = KIND_FULL;
                            o_last     = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_VP;
                    end
                end else begin
                    // collision, walk to the next slot
                    ht_raddr = h_reg + 1'b1;
                    h_next   = h_reg + 1'b1;
                end
            end
            ST_VP: begin
                v_raddr    = ep;
                state_next = ST_VQ;
            end
            ST_VQ: begin
                v_raddr    = eq;
                state_next = ST_VS;
            end
            ST_VS: begin
                state_next = ST_MID;
            end
            ST_MID: begin
                if (out_free) begin
                    v_we         = 1'b1;
                    ht_we        = 1'b1;
                    mid_we       = 1'b1;
                    mid_idx_next = vcount_reg[IDX_W-1:0];
                    out_load     = 1'b1;
                    o_idx        = vcount_reg[IDX_W-1:0];
                    o_x          = 32'(mx_reg);
                    o_y          = 32'(my_reg);
                    o_z          = 32'(mz_reg);
                    vcount_next  = vcount_reg + 1'b1;
                    ecount_next  = ecount_reg + 1'b1;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (edge_reg == 2'd2) begin
                    state_next = ST_TRI;
                end else begin
                    edge_next  = edge_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_TRI: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    o_kind    = KIND_TRI;
                    o_t0      = tt0;
                    o_t1      = tt1;
                    o_t2      = tt2;
                    o_last    = (3'(tcnt_reg) + 3'd1) == ntri;
                    tcnt_next = tcnt_reg + 1'b1;
                    if (o_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            vcount_reg     <= '0;
            ecount_reg     <= '0;
            epoch_reg      <= EPOCH_ONE;
            clr_addr_reg   <= '0;
            split_mode_reg <= 1'b0;
            z_thr_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            ecount_reg   <= ecount_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SPLIT_MODE:  split_mode_reg <= cfg_data[0];
                    REG_Z_THRESHOLD: z_thr_reg      <= cfg_data;
                    default:         ;
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        edge_reg <= edge_next;
        h_reg    <= h_next;
        hits_reg <= hits_next;
        big_reg  <= big_next;
        tcnt_reg <= tcnt_next;
        if (s_fire) begin
            cmd_reg   <= s_tuser;
            px_in_reg <= s_tdata[31:0];
            py_in_reg <= s_tdata[63:32];
            pz_in_reg <= s_tdata[95:64];
            va_reg    <= s_tdata[107:96];
            vb_reg    <= s_tdata[119:108];
            vc_reg    <= s_tdata[131:120];
        end
        if (mid_we) begin
            case (edge_reg)
                2'd0:    mab_reg <= mid_idx_next;
                2'd1:    mac_reg <= mid_idx_next;
                default: mcb_reg <= mid_idx_next;
            endcase
        end
        if (state_reg == ST_VQ) begin
            ax_reg <= x_rd;
            ay_reg <= y_rd;
            az_reg <= z_rd;
        end
        if (state_reg == ST_VS) begin
            mx_reg <= sx[CW:1];
            my_reg <= sy[CW:1];
            mz_reg <= sz[CW:1];
        end
        if (out_load) begin
            out_kind_reg <= o_kind;
            out_idx_reg  <= o_idx;
            out_x_reg    <= o_x;
            out_y_reg    <= o_y;
            out_z_reg    <= o_z;
            out_t0_reg   <= o_t0;
            out_t1_reg   <= o_t1;
            out_t2_reg   <= o_t2;
            out_last_reg <= o_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_t2_reg, out_t1_reg, out_t0_reg,
                       out_z_reg, out_y_reg, out_x_reg, out_idx_reg};

endmodule

### dv/tb_midpoint_triangle_subdivider_unit.sv
// testbench for midpoint_triangle_subdivider_unit: directed table, a store-full phase,
// then random command traffic under several split settings; depends on mts_pkg and the rtl
`timescale 1ns / 1ps

module tb_midpoint_triangle_subdivider_unit;
    import mts_pkg::*;

    localparam int NUM_SLOTS = 4096;

    // one result as seen on the master side
    typedef struct {
        logic [1:0]  kind;
        logic [11:0] idx;
        logic [31:0] x, y, z;
        logic [11:0] t0, t1, t2;
        logic        last;
    } mesh_out_t;

    // one directed request, typed expectation only where obvious
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] x, y, z;
        logic [11:0] a, b, c;
        bit          chk;
        logic [1:0]  ekind;
        logic [11:0] eidx;
    } mesh_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // pos_x, pos_y, pos_z, vert_a, vert_b, vert_c, 4 zero bits
    logic [135:0] s_tdata = '0;
    // cmd
    logic [1:0]   s_tuser = CMD_APPEND;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_index, mid_x, mid_y, mid_z, tri_first, tri_second, tri_third
    logic [143:0] m_tdata;
    // kind
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = REG_SPLIT_MODE;
    logic [31:0]  cfg_data = '0;

    midpoint_triangle_subdivider_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // mirror of the block: vertex stores, counters, edge cache, registers
    logic signed [31:0] mesh_x [NUM_SLOTS];
    logic signed [31:0] mesh_y [NUM_SLOTS];
    logic signed [31:0] mesh_z [NUM_SLOTS];
    int                 vert_count = 0;
    int                 vert_hwm = 0;      // entries below this were written at least once
    logic [11:0]        edge_mid [int];    // keyed by the ordered index pair
    logic               mode_cond = 1'b0;
    logic signed [31:0] z_limit = '0;

    mesh_out_t   pending_q [$];
    int          err_count = 0;
    int          req_count = 0;
    int          out_count = 0;
    int          full_count = 0;
    int          defer_count = 0;
    bit          no_idle = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 40)
            $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic int edge_key(input logic [11:0] p, input logic [11:0] q);
        return int'((p < q) ? {p, q} : {q, p});
    endfunction

    function automatic logic [31:0] half_sum(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
        logic signed [32:0] s;
        s = {p[31], p} + {q[31], q};
        return s[32:1];
    endfunction

    task automatic push_out(input logic [1:0] kind, input logic [11:0] idx,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [11:0] t0,
                            input logic [11:0] t1, input logic [11:0] t2);
        mesh_out_t r;
        r = '{kind, idx, x, y, z, t0, t1, t2, 1'b0};
        pending_q = {pending_q, r};
    endtask

    // cached midpoint of an edge, or a new one; ok low when a store is full
    task automatic get_midpoint(input logic [11:0] p, input logic [11:0] q,
                                output bit ok, output logic [11:0] m);
        int k;
        k = edge_key(p, q);
        ok = 1'b1;
        if (edge_mid.exists(k)) begin
            m = edge_mid[k];
        end else if (vert_count >= NUM_SLOTS) begin
            push_out(KIND_FULL, 0, 0, 0, 0, 0, 0, 0);
            ok = 1'b0;
            m = '0;
        end else begin
            m = vert_count[11:0];
            mesh_x[m] = half_sum(mesh_x[p], mesh_x[q]);
            mesh_y[m] = half_sum(mesh_y[p], mesh_y[q]);
            mesh_z[m] = half_sum(mesh_z[p], mesh_z[q]);
            vert_count++;
            if (vert_count > vert_hwm) vert_hwm = vert_count;
            edge_mid[k] = m;
            push_out(KIND_VERTEX, m, mesh_x[m], mesh_y[m], mesh_z[m], 0, 0, 0);
        end
    endtask

    task automatic tri_out(input logic [11:0] p, input logic [11:0] q, input logic [11:0] r);
        push_out(KIND_TRI, 0, 0, 0, 0, p, q, r);
    endtask

    task automatic quad_out(input logic [11:0] a, input logic [11:0] b, input logic [11:0] c,
                            input logic [11:0] ab, input logic [11:0] ac,
                            input logic [11:0] cb);
        tri_out(a, ab, ac);
        tri_out(b, cb, ab);
        tri_out(c, ac, cb);
        tri_out(ab, cb, ac);
    endtask

    // expected results of one accepted request; first gives the first of them
    task automatic predict_mesh(input mesh_req_t q, output bit any, output mesh_out_t first);
        int          n0;
        bit          ok, hab, hac, hcb;
        logic [11:0] ab, ac, cb;
        n0 = pending_q.size();
        ab = '0; ac = '0; cb = '0;
        case (q.cmd)
            CMD_APPEND: begin
                if (vert_count >= NUM_SLOTS) begin
                    push_out(KIND_FULL, 0, 0, 0, 0, 0, 0, 0);
                end else begin
                    mesh_x[vert_count] = q.x;
                    mesh_y[vert_count] = q.y;
                    mesh_z[vert_count] = q.z;
                    push_out(KIND_VERTEX, vert_count[11:0], q.x, q.y, q.z, 0, 0, 0);
                    vert_count++;
                    if (vert_count > vert_hwm) vert_hwm = vert_count;
                end
            end
            CMD_SPLIT: begin
                if (mode_cond && !(mesh_z[q.a] > z_limit || mesh_z[q.b] > z_limit ||
                                   mesh_z[q.c] > z_limit)) begin
                    push_out(KIND_DEFER, 0, 0, 0, 0, q.a, q.b, q.c);
                end else begin
                    get_midpoint(q.a, q.b, ok, ab);
                    if (ok) get_midpoint(q.a, q.c, ok, ac);
                    if (ok) get_midpoint(q.c, q.b, ok, cb);
                    if (ok) quad_out(q.a, q.b, q.c, ab, ac, cb);
                end
            end
            CMD_FILL: begin
                hab = edge_mid.exists(edge_key(q.a, q.b));
                hac = edge_mid.exists(edge_key(q.a, q.c));
                hcb = edge_mid.exists(edge_key(q.c, q.b));
                if (hab) ab = edge_mid[edge_key(q.a, q.b)];
                if (hac) ac = edge_mid[edge_key(q.a, q.c)];
                if (hcb) cb = edge_mid[edge_key(q.c, q.b)];
                if (hab && hac && hcb) begin
                    quad_out(q.a, q.b, q.c, ab, ac, cb);
                end else if (hab && hac) begin
                    tri_out(ab, ac, q.a);
                    tri_out(q.c, ac, q.b);
                    tri_out(q.b, ac, ab);
                end else if (hab) begin
                    tri_out(q.a, ab, q.c);
                    tri_out(q.b, q.c, ab);
                end else if (hac && hcb) begin
                    tri_out(q.a, cb, ac);
                    tri_out(ac, cb, q.c);
                    tri_out(q.b, cb, q.a);
                end else if (hac) begin
                    tri_out(q.a, q.b, ac);
                    tri_out(q.b, q.c, ac);
                end else if (hcb) begin
                    tri_out(q.a, cb, q.c);
                    tri_out(q.a, q.b, cb);
                end else begin
                    tri_out(q.a, q.b, q.c);
                end
            end
            default: begin
                vert_count = 0;
                edge_mid.delete();
            end
        endcase
        any = pending_q.size() > n0;
        if (any) begin
            pending_q[pending_q.size()-1].last = 1'b1;
            first = pending_q[n0];
        end
    endtask

    // drive one request and hold it until taken; prediction happens at the accepting edge
    task automatic send_req(input mesh_req_t q);
        bit        any;
        mesh_out_t first;
        if (!no_idle && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.cmd;
        s_tdata  <= {4'b0, q.c, q.b, q.a, q.z, q.y, q.x};
        do @(posedge aclk); while (!s_tready);
        req_count++;
        predict_mesh(q, any, first);
        if (q.chk) begin
            if (!any) begin
                report_mismatch("typed result missing", 0, q.ekind);
            end else begin
                if (first.kind !== q.ekind) report_mismatch("typed kind", first.kind, q.ekind);
                if (first.idx !== q.eidx) report_mismatch("typed index", first.idx, q.eidx);
            end
        end
    endtask

    // wait for every expected result, then for the block to settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SPLIT_MODE) mode_cond = data[0];
        else z_limit = data;
        @(posedge aclk);
    endtask

    function automatic logic [11:0] pick_corner();
        if (vert_count > 0 && $urandom_range(3) != 0)
            return 12'($urandom_range(vert_count - 1));
        return 12'($urandom_range(vert_hwm - 1));
    endfunction

    // master side: check each result against the oldest expectation
    always @(posedge aclk) begin
        mesh_out_t w;
        m_tready <= no_idle || ($urandom_range(99) >= 36);
        if (aresetn && m_tvalid && m_tready) begin
            out_count++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result kind", m_tuser, 0);
            end else begin
                w = pending_q.pop_front();
                if (m_tuser === KIND_FULL) full_count++;
                if (m_tuser === KIND_DEFER) defer_count++;
                if (m_tuser !== w.kind) report_mismatch("kind", m_tuser, w.kind);
                if (m_tdata[11:0] !== w.idx) report_mismatch("new_index", m_tdata[11:0], w.idx);
                if (m_tdata[43:12] !== w.x) report_mismatch("mid_x", m_tdata[43:12], w.x);
                if (m_tdata[75:44] !== w.y) report_mismatch("mid_y", m_tdata[75:44], w.y);
                if (m_tdata[107:76] !== w.z) report_mismatch("mid_z", m_tdata[107:76], w.z);
                if (m_tdata[119:108] !== w.t0)
                    report_mismatch("tri_first", m_tdata[119:108], w.t0);
                if (m_tdata[131:120] !== w.t1)
                    report_mismatch("tri_second", m_tdata[131:120], w.t1);
                if (m_tdata[143:132] !== w.t2)
                    report_mismatch("tri_third", m_tdata[143:132], w.t2);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
        end
    end

    initial begin
        mesh_req_t   dir_tab [];
        mesh_req_t   q;
        logic [31:0] phase_lim [4];
        logic [11:0] last_a, last_b, last_c;
        int          r;

        // directed: coordinate extremes, first split, fill patterns but ab without ac, degenerate edge,
        // clear restarting the vertex count
        dir_tab = '{
            '{CMD_APPEND, 32'h7fffffff, 32'h80000000, 32'h0, 0, 0, 0, 1, KIND_VERTEX, 0},
            '{CMD_APPEND, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0, 0, 1, KIND_VERTEX, 1},
            '{CMD_APPEND, 32'h1, 32'hffffffff, 32'h7fffffff, 0, 0, 0, 1, KIND_VERTEX, 2},
            '{CMD_APPEND, 32'h0, 32'h0, 32'h80000000, 0, 0, 0, 1, KIND_VERTEX, 3},
            '{CMD_SPLIT, 0, 0, 0, 0, 1, 2, 1, KIND_VERTEX, 4},
            '{CMD_SPLIT, 0, 0, 0, 0, 1, 2, 1, KIND_TRI, 0},
            '{CMD_SPLIT, 0, 0, 0, 1, 3, 0, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 0, 1, 2, 1, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 0, 2, 3, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 2, 3, 0, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 5, 0, 1, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 0, 5, 1, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 4, 5, 6, 0, KIND_TRI, 0},
            '{CMD_FILL, 0, 0, 0, 1, 0, 3, 0, KIND_TRI, 0},
            '{CMD_SPLIT, 0, 0, 0, 2, 2, 3, 0, KIND_TRI, 0},
            '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, KIND_TRI, 0},
            '{CMD_APPEND, 32'h00018000, 32'hfffe8000, 32'h0, 0, 0, 0, 1, KIND_VERTEX, 0},
            '{CMD_FILL, 0, 0, 0, 0, 1, 2, 1, KIND_TRI, 0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(REG_SPLIT_MODE, 32'd0);
        write_reg(REG_Z_THRESHOLD, 32'd0);

        foreach (dir_tab[i]) send_req(dir_tab[i]);
        drain();

        // store-full phase, run without any idling on either side
        no_idle = 1'b1;
        send_req('{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, KIND_TRI, 0});
        while (vert_count < NUM_SLOTS - 2)
            send_req('{CMD_APPEND, $urandom, $urandom, $urandom, 0, 0, 0, 0, KIND_TRI, 0});
        send_req('{CMD_SPLIT, 0, 0, 0, 0, 1, 2, 0, KIND_TRI, 0});
        send_req('{CMD_APPEND, 1, 2, 3, 0, 0, 0, 1, KIND_FULL, 0});
        send_req('{CMD_SPLIT, 0, 0, 0, 0, 1, 2, 0, KIND_TRI, 0});
        send_req('{CMD_FILL, 0, 0, 0, 4095, 4095, 4094, 0, KIND_TRI, 0});
        send_req('{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, KIND_TRI, 0});
        drain();
        no_idle = 1'b0;

        // random phases: always split, never split, split on any z above minimum, split on random level
        phase_lim = '{32'h0, 32'h7fffffff, 32'h80000000, $urandom};
        last_a = 0; last_b = 1; last_c = 2;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_SPLIT_MODE, (ph == 0) ? 32'd0 : 32'd1);
            write_reg(REG_Z_THRESHOLD, phase_lim[ph]);
            for (int n = 0; n < 103; n++) begin
                r = $urandom_range(99);
                q = '{CMD_APPEND, $urandom, $urandom, $urandom, 0, 0, 0, 0, KIND_TRI, 0};
                if (r >= 30 && r < 93) begin
                    q.cmd = (r < 62) ? CMD_SPLIT : CMD_FILL;
                    case ($urandom_range(9))
                        0, 1, 2: begin
                            // revisit the last triangle, rotated or flipped
                            q.a = last_b; q.b = last_c; q.c = last_a;
                            if ($urandom_range(1)) begin q.a = last_c; q.c = last_b; end
                        end
                        3: begin q.a = pick_corner(); q.b = q.a; q.c = pick_corner(); end
                        default: begin
                            q.a = pick_corner(); q.b = pick_corner(); q.c = pick_corner();
                        end
                    endcase
                    last_a = q.a; last_b = q.b; last_c = q.c;
                end else if (r >= 93) begin
                    q.cmd = CMD_CLEAR;
                end
                send_req(q);
            end
            drain();
        end

        $display("covered %0d requests and %0d results, %0d store-full and %0d deferred",
                 req_count, out_count, full_count, defer_count);
        $display("split settings: always, never, any z above minimum, random z level");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit, covering the reset sweep and the sweeps on every fifteenth clear
    initial begin
        #8ms;
        $display("run limit reached with %0d results still expected", pending_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
